// File: hw/rtl/fdc_pkg.sv
// Shared types, constants and helpers for the fan delay on/off controller.
`timescale 1ns / 1ps

package fdc_pkg;

  localparam int unsigned CntW      = 32;
  localparam int unsigned LimitW    = 22;     // holds 255 * 10000
  localparam int unsigned UnitMs    = 10 * 1000;
  localparam int unsigned NumLights = 6;
  localparam int unsigned LightBits = 6;

  // Configuration register indexes
  localparam logic [2:0] CfgRelayAddr = 3'd0;
  localparam logic [2:0] CfgOnUnits   = 3'd1;
  localparam logic [2:0] CfgOffUnits  = 3'd2;
  localparam logic [2:0] CfgLightA    = 3'd3;
  localparam logic [2:0] CfgLightB    = 3'd4;
  localparam logic [2:0] CfgLocalPin  = 3'd5;
  localparam logic [2:0] CfgModeSel   = 3'd6;

  typedef enum logic [1:0] {
    CmdService = 2'd0,
    CmdOn      = 2'd1,
    CmdOff     = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [15:0]       relay_addr;
    logic [7:0]        on_units;
    logic [7:0]        off_units;
    logic [LimitW-1:0] on_limit;
    logic [LimitW-1:0] off_limit;
    logic [2:0]        light_a;
    logic [2:0]        light_b;
    logic [7:0]        pin_num;
    logic              mode_sel;
  } fdc_cfg_t;

  typedef struct packed {
    logic [CntW-1:0] ms_count;
    logic [CntW-1:0] ms_inc;      // always ms_count + 1
    logic [CntW-1:0] on_stamp;
    logic [CntW-1:0] off_stamp;
    logic            fan_active;
    logic            last_trigger;
    logic            last_reported;
  } fdc_state_t;

  typedef struct packed {
    logic fan_on;
    logic send;
    logic drive;
    logic icon;
  } fdc_result_t;

  // A stamp of zero marks an idle timer, so store zero as one.
  function automatic logic [CntW-1:0] take_stamp(logic [CntW-1:0] ms);
    return (ms == '0) ? CntW'(1) : ms;
  endfunction

  function automatic logic light_active(logic [2:0] num, logic [LightBits-1:0] lights);
    logic [2:0] idx;
    idx = num - 3'd1;
    if (num == 3'd0 || 32'(num) > NumLights || 32'(num) > LightBits) begin
      return 1'b0;
    end
    return lights[idx];
  endfunction

endpackage

// File: hw/rtl/fan_delay_on_off_controller_top.sv
// Top level of the fan controller with delay-on and delay-off timers.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: cmd_i selects a
//   service pass (one millisecond tick), switch on or switch off; use_delay_i
//   asks switch on to honor the on delay; light_states_i feeds the trigger
//   lights read on a service pass.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   item per input item, in order: fan_on_o, send_relay_level_o, drive_pin_o
//   and icon_update_o.
//   An accepted item is held in the input register; when it advances, the
//   next-state logic writes the timer state and the result register at the
//   same edge. Throughput is one item per cycle while the receiver does not
//   stall; the path that sets it is a single 32-bit subtract-and-compare
//   per timer.
//   When the receiver stalls, the result register holds and one more item
//   waits in the input register; in_stall_o rises only when both are full.
//   Configuration is a write port (cfg_we_i, cfg_index_i, cfg_wdata_i) for
//   the user to write only while the block is idle (the block does not enforce
//   it); delay limits are scaled to milliseconds at write time. Reset clears
//   all configuration, the millisecond counter, both timers and the fan, trigger and reported levels.
module fan_delay_on_off_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        use_delay_i,
  input  logic [5:0]  light_states_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        fan_on_o,
  output logic        send_relay_level_o,
  output logic        drive_pin_o,
  output logic        icon_update_o
);
  import fdc_pkg::*;

  fdc_cfg_t    cfg_q, cfg_d;
  fdc_state_t  state_q, state_d;
  fdc_result_t res_q, res_d;

  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic       use_delay_q;
  logic [5:0] lights_q;
  logic       out_valid_q;

  logic advance;     // the held item moves into the result register
  logic in_accept;

  // ---------------------------------------------------------------------
  // Configuration: decode the index, pre-scale delays to milliseconds.
  // ---------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRelayAddr: cfg_d.relay_addr = cfg_wdata_i;
        CfgOnUnits: begin
          cfg_d.on_units = cfg_wdata_i[7:0];
          cfg_d.on_limit = LimitW'(cfg_wdata_i[7:0] * LimitW'(UnitMs));
        end
        CfgOffUnits: begin
          cfg_d.off_units = cfg_wdata_i[7:0];
          cfg_d.off_limit = LimitW'(cfg_wdata_i[7:0] * LimitW'(UnitMs));
        end
        CfgLightA:   cfg_d.light_a   = cfg_wdata_i[2:0];
        CfgLightB:   cfg_d.light_b   = cfg_wdata_i[2:0];
        CfgLocalPin: cfg_d.pin_num   = cfg_wdata_i[7:0];
        CfgModeSel:  cfg_d.mode_sel  = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: advance when the result register is empty or being taken;
  // accept a new item whenever the input register frees up.
  // ---------------------------------------------------------------------
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept || advance) begin
      in_valid_q <= in_accept;
    end
  end

  // Input payload: capture on accept only.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q       <= cmd_i;
      use_delay_q <= use_delay_i;
      lights_q    <= light_states_i;
    end
  end

  // ---------------------------------------------------------------------
  // Item logic: timer state updates as the item enters the result register.
  // ---------------------------------------------------------------------
  fdc_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .cmd_i          (cmd_q),
    .use_delay_i    (use_delay_q),
    .light_states_i (lights_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{ms_inc: CntW'(1), default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold while stalled, load on advance.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fan_on_o           = res_q.fan_on;
  assign send_relay_level_o = res_q.send;
  assign drive_pin_o        = res_q.drive;
  assign icon_update_o      = res_q.icon;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Back-pressure reaches the input only when a result is held by the receiver.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled without a held result");

  // The look-ahead counter always leads the millisecond counter by one.
  a_ms_inc_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ms_inc == state_q.ms_count + CntW'(1))
    else $error("millisecond look-ahead counter out of step");

  // Commands other than a service pass never report relay, pin or icon.
  a_cmd_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q != CmdService) |=> !(res_q.send || res_q.drive || res_q.icon))
    else $error("report flag set by a non-service item");

  // Time advances only on service items.
  a_time_only_on_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q != CmdService) |=> $stable(state_q.ms_count))
    else $error("millisecond counter moved on a command item");

endmodule

// File: hw/rtl/fdc_step.sv
// Next-state and result logic for one item of the fan controller.
`timescale 1ns / 1ps

module fdc_step (
  input  fdc_pkg::fdc_cfg_t    cfg_i,
  input  fdc_pkg::fdc_state_t  state_i,
  input  logic [1:0]           cmd_i,
  input  logic                 use_delay_i,
  input  logic [5:0]           light_states_i,
  output fdc_pkg::fdc_state_t  state_o,
  output fdc_pkg::fdc_result_t result_o
);
  import fdc_pkg::*;

  cmd_e            cmd;
  logic            configured;
  logic [CntW-1:0] stamp_cmd;
  logic [CntW-1:0] stamp_tick;
  logic [CntW-1:0] on_elapsed;
  logic [CntW-1:0] off_elapsed;
  logic            on_due;
  logic            off_due;
  logic            trig;

  assign cmd        = cmd_e'(cmd_i);
  assign configured = (cfg_i.relay_addr != '0) || (cfg_i.pin_num != '0);
  assign stamp_cmd  = take_stamp(state_i.ms_count);
  assign stamp_tick = take_stamp(state_i.ms_inc);

  // Elapsed time is measured against the advanced counter.
  assign on_elapsed  = state_i.ms_inc - state_i.on_stamp;
  assign off_elapsed = state_i.ms_inc - state_i.off_stamp;
  assign on_due  = (state_i.on_stamp != '0) &&
                   (on_elapsed >= CntW'(cfg_i.on_limit));
  assign off_due = (state_i.off_stamp != '0) &&
                   (off_elapsed >= CntW'(cfg_i.off_limit));

  assign trig = light_active(cfg_i.light_a, light_states_i) ||
                light_active(cfg_i.light_b, light_states_i);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (cmd)
      CmdOn: begin
        if (configured) begin
          state_o.off_stamp = '0;
          if (use_delay_i && cfg_i.on_units != '0) begin
            state_o.on_stamp = stamp_cmd;
          end else begin
            state_o.on_stamp   = '0;
            state_o.fan_active = 1'b1;
            if (cfg_i.off_units != '0) begin
              state_o.off_stamp = stamp_cmd;
            end
          end
        end
      end
      CmdOff: begin
        if (configured) begin
          state_o.on_stamp   = '0;
          state_o.off_stamp  = '0;
          state_o.fan_active = 1'b0;
        end
      end
      CmdService: begin
        state_o.ms_count = state_i.ms_inc;
        state_o.ms_inc   = state_i.ms_inc + CntW'(1);
        if (configured && cfg_i.mode_sel) begin
          if (off_due) begin
            state_o.fan_active = 1'b0;
            state_o.off_stamp  = '0;
            result_o.icon      = 1'b1;
          end
          if (on_due) begin
            state_o.fan_active = 1'b1;
            state_o.on_stamp   = '0;
            result_o.icon      = 1'b1;
          end
          if (trig != state_i.last_trigger) begin
            if (trig) begin
              state_o.off_stamp = '0;
              if (cfg_i.on_units != '0) begin
                state_o.on_stamp = stamp_tick;
              end else begin
                state_o.on_stamp   = '0;
                state_o.fan_active = 1'b1;
                if (cfg_i.off_units != '0) begin
                  state_o.off_stamp = stamp_tick;
                end
              end
            end else if (cfg_i.off_units != '0) begin
              state_o.off_stamp = stamp_tick;
            end
          end
          state_o.last_trigger = trig;
          if (state_i.last_reported != state_o.fan_active) begin
            result_o.send         = (cfg_i.relay_addr != '0);
            state_o.last_reported = state_o.fan_active;
          end
          result_o.drive = (cfg_i.pin_num != '0);
        end
      end
      default: begin
      end
    endcase
    result_o.fan_on = state_o.fan_active;
  end

endmodule
